@@ rtl/assert_macros.svh @@
// assertion helpers included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/drp_pkg.sv @@
`timescale 1ns / 1ps

package drp_pkg;

  // field widths
  localparam int HEAD_W  = 10;
  localparam int COUNT_W = 32;
  localparam int ACC_W   = 64;

  // |step| * 1000 fits in 41 bits, split into a 21-bit low and a 20-bit high part for the multiplier
  localparam int MAG_W   = 41;
  localparam int SPLIT_W = 21;
  localparam int HI_W    = MAG_W - SPLIT_W;

  // trig magnitudes are stored at the widest fraction width
  localparam int TRIG_MAG_W = 30;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // partial product widths and the recombined product width
  localparam int PLO_W  = SPLIT_W + TRIG_MAG_W;
  localparam int PHI_W  = HI_W + TRIG_MAG_W;
  localparam int FULL_W = MAG_W + TRIG_MAG_W + 1;

  // scaled step magnitude after the fraction shift
  localparam int STEP_W = MAG_W + 1;

  localparam logic [MUL_W-1:0] SCALE = 32'd1000;

  // angle constants
  localparam logic [11:0] FULL_TURN_X2 = 12'd720;
  localparam logic [11:0] FULL_TURN    = 12'd360;
  localparam logic [8:0]  DEG_90       = 9'd90;
  localparam logic [8:0]  DEG_180      = 9'd180;
  localparam logic [8:0]  DEG_270      = 9'd270;

  typedef logic [90:0][TRIG_MAG_W-1:0] trig_tab_t;

  // sine and cosine magnitudes plus signs for one heading
  typedef struct packed {
    logic [TRIG_MAG_W-1:0] sin_mag;
    logic [TRIG_MAG_W-1:0] cos_mag;
    logic                  sin_neg;
    logic                  cos_neg;
  } trig_t;

  // sin(d degrees) in Q30 by a nine-term series, then rounded to frac bits
  function automatic logic [TRIG_MAG_W-1:0] trig_entry(int unsigned d, int unsigned frac);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic signed [63:0] maxv;
    int unsigned s;
    x    = 64'(d) * 64'd18740330;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    s    = 30 - frac;
    v    = sum;
    maxv = (64'sd1 <<< frac) - 64'sd1;
    if (s > 0) begin
      v = (v + (64'sd1 <<< (s - 1))) >>> s;
    end
    if (v > maxv) begin
      v = maxv;
    end
    return v[TRIG_MAG_W-1:0];
  endfunction

  // whole-degree table for 0..90 degrees
  function automatic trig_tab_t build_trig_tab(int unsigned frac);
    trig_tab_t tab;
    for (int unsigned d = 0; d <= 90; d++) begin
      tab[d] = trig_entry(d, frac);
    end
    return tab;
  endfunction

endpackage

@@ rtl/drp_if.sv @@
`timescale 1ns / 1ps

// input channel: heading and encoder count per tick
interface drp_tick_if;
  logic                               valid;
  logic                               ready;
  logic signed [drp_pkg::HEAD_W-1:0]  heading_deg;
  logic signed [drp_pkg::COUNT_W-1:0] encoder_count;

  modport source (output valid, output heading_deg, output encoder_count, input ready);
  modport sink   (input valid, input heading_deg, input encoder_count, output ready);
endinterface

// output channel: position and heading per tick
interface drp_pose_if;
  logic                              valid;
  logic                              ready;
  logic signed [drp_pkg::ACC_W-1:0]  x_scaled;
  logic signed [drp_pkg::ACC_W-1:0]  y_scaled;
  logic signed [drp_pkg::HEAD_W-1:0] heading_out;

  modport source (output valid, output x_scaled, output y_scaled, output heading_out,
                  input ready);
  modport sink   (input valid, input x_scaled, input y_scaled, input heading_out,
                  output ready);
endinterface

@@ rtl/drp_mul.sv @@
`timescale 1ns / 1ps

// shared unsigned multiplier with a registered product
module drp_mul (
  input  logic                        clk,
  input  logic [drp_pkg::MUL_W-1:0]   a,
  input  logic [drp_pkg::MUL_W-1:0]   b,
  output logic [drp_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= drp_pkg::PROD_W'(a) * drp_pkg::PROD_W'(b);
  end

endmodule

@@ rtl/drp_angle.sv @@
`timescale 1ns / 1ps

// heading reduction and sine/cosine lookup, registered on load
module drp_angle #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [drp_pkg::HEAD_W-1:0] heading,
  output drp_pkg::trig_t                    trig
);

  localparam drp_pkg::trig_tab_t TRIG_TAB = drp_pkg::build_trig_tab(TRIG_FRAC_BITS);

  logic [11:0]    hx;
  logic [8:0]     deg;
  logic [1:0]     quad;
  logic [8:0]     base;
  logic [6:0]     d;
  logic [6:0]     dc;
  logic [drp_pkg::TRIG_MAG_W-1:0] s;
  logic [drp_pkg::TRIG_MAG_W-1:0] c;
  drp_pkg::trig_t trig_next;

  // modulo 360 by one offset and three conditional subtracts
  always_comb begin
    hx = {{2{heading[drp_pkg::HEAD_W-1]}}, heading};
    if (heading[drp_pkg::HEAD_W-1]) begin
      hx = hx + drp_pkg::FULL_TURN_X2;
    end
    for (int i = 0; i < 3; i++) begin
      if (hx >= drp_pkg::FULL_TURN) begin
        hx = hx - drp_pkg::FULL_TURN;
      end
    end
    deg = hx[8:0];
  end

  // quadrant and angle within it
  always_comb begin
    priority if (deg >= drp_pkg::DEG_270) begin
      quad = 2'd3;
      base = drp_pkg::DEG_270;
    end else if (deg >= drp_pkg::DEG_180) begin
      quad = 2'd2;
      base = drp_pkg::DEG_180;
    end else if (deg >= drp_pkg::DEG_90) begin
      quad = 2'd1;
      base = drp_pkg::DEG_90;
    end else begin
      quad = 2'd0;
      base = 9'd0;
    end
    d  = 7'(deg - base);
    dc = 7'(7'd90 - d);
  end

  // table lookup and quadrant symmetry
  always_comb begin
    s = TRIG_TAB[d];
    c = TRIG_TAB[dc];
    trig_next.sin_mag = quad[0] ? c : s;
    trig_next.cos_mag = quad[0] ? s : c;
    trig_next.sin_neg = quad[1];
    trig_next.cos_neg = quad[1] ^ quad[0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trig <= trig_next;
    end
  end

endmodule

@@ rtl/drp_satadd.sv @@
`timescale 1ns / 1ps

// saturating add or subtract of a product magnitude to an accumulator
module drp_satadd (
  input  logic signed [drp_pkg::ACC_W-1:0] acc,
  input  logic [drp_pkg::STEP_W-1:0]       mag,
  input  logic                             sub,
  output logic signed [drp_pkg::ACC_W-1:0] sum
);

  localparam int EXT_W = drp_pkg::ACC_W + 1;

  logic [EXT_W-1:0] acc_ext;
  logic [EXT_W-1:0] mag_ext;
  logic [EXT_W-1:0] raw;

  always_comb begin
    acc_ext = {acc[drp_pkg::ACC_W-1], acc};
    mag_ext = EXT_W'(mag);
    raw     = sub ? acc_ext - mag_ext : acc_ext + mag_ext;
    // clamp when the extra sign bit disagrees
    if (raw[EXT_W-1] != raw[EXT_W-2]) begin
      sum = raw[EXT_W-1] ? {1'b1, {(drp_pkg::ACC_W-1){1'b0}}}
                         : {1'b0, {(drp_pkg::ACC_W-1){1'b1}}};
    end else begin
      sum = raw[drp_pkg::ACC_W-1:0];
    end
  end

endmodule

@@ rtl/dead_reckoning_position.sv @@
`timescale 1ns / 1ps
// sequence: five passes through the shared 32x32 multiplier (S_MAG, S_XLO, S_XHI, S_YLO,
//   S_YHI), with combine and accumulate steps, then S_YCMB, S_YACC and S_OUT, which posts
//   the result on pose once pose is free; a new tick is taken only in S_IDLE
// a finished result may wait on pose while the next transaction is taken
// reset: clears the x and y accumulators, the stored encoder count,
//   the sequencer and the output valid
module dead_reckoning_position #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  drp_tick_if.sink          tick,
  drp_pose_if.source        pose
);

  `include "assert_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MAG  = 9'b000000010,
    S_XLO  = 9'b000000100,
    S_XHI  = 9'b000001000,
    S_YLO  = 9'b000010000,
    S_YHI  = 9'b000100000,
    S_YCMB = 9'b001000000,
    S_YACC = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [drp_pkg::COUNT_W-1:0]       last_count;
  logic [drp_pkg::COUNT_W-1:0]       diff;
  logic [drp_pkg::COUNT_W-1:0]       step_mag;
  logic                              step_neg;
  logic signed [drp_pkg::HEAD_W-1:0] head_reg;
  logic signed [drp_pkg::ACC_W-1:0]  x_accum;
  logic signed [drp_pkg::ACC_W-1:0]  y_accum;
  logic [drp_pkg::MAG_W-1:0]         m_reg;
  logic [drp_pkg::PLO_W-1:0]         lo_reg;
  logic [drp_pkg::STEP_W-1:0]        prod_reg;
  logic [drp_pkg::FULL_W-1:0]        full;
  logic                              out_valid;
  logic                              accept;
  logic                              out_free;

  logic [drp_pkg::MUL_W-1:0]  mul_a;
  logic [drp_pkg::MUL_W-1:0]  mul_b;
  logic [drp_pkg::PROD_W-1:0] mul_p;

  drp_pkg::trig_t             trig;

  logic signed [drp_pkg::ACC_W-1:0] sat_acc;
  logic                             sat_sub;
  logic signed [drp_pkg::ACC_W-1:0] sat_sum;

  assign accept     = tick.valid && tick.ready;
  assign out_free   = !out_valid || pose.ready;
  assign tick.ready = (state == S_IDLE);

  // angle reduction and table lookup
  drp_angle #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_angle (
    .clk     (clk),
    .load    (accept),
    .heading (tick.heading_deg),
    .trig    (trig)
  );

  // shared multiplier
  drp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // shared saturating accumulator adder
  drp_satadd u_satadd (
    .acc (sat_acc),
    .mag (prod_reg),
    .sub (sat_sub),
    .sum (sat_sum)
  );

  // encoder step as the difference from the stored count, split into sign and magnitude on accept
  always_comb begin
    diff = tick.encoder_count - last_count;
  end

  // multiplier operand select per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MAG: begin
        mul_a = step_mag;
        mul_b = drp_pkg::SCALE;
      end
      S_XLO: begin
        mul_a = drp_pkg::MUL_W'(mul_p[drp_pkg::SPLIT_W-1:0]);
        mul_b = drp_pkg::MUL_W'(trig.cos_mag);
      end
      S_XHI: begin
        mul_a = drp_pkg::MUL_W'(m_reg[drp_pkg::MAG_W-1:drp_pkg::SPLIT_W]);
        mul_b = drp_pkg::MUL_W'(trig.cos_mag);
      end
      S_YLO: begin
        mul_a = drp_pkg::MUL_W'(m_reg[drp_pkg::SPLIT_W-1:0]);
        mul_b = drp_pkg::MUL_W'(trig.sin_mag);
      end
      S_YHI: begin
        mul_a = drp_pkg::MUL_W'(m_reg[drp_pkg::MAG_W-1:drp_pkg::SPLIT_W]);
        mul_b = drp_pkg::MUL_W'(trig.sin_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // recombine the high and low partial products; the fraction is truncated when prod_reg loads
  always_comb begin
    full = {1'b0, mul_p[drp_pkg::PHI_W-1:0], {drp_pkg::SPLIT_W{1'b0}}}
         + drp_pkg::FULL_W'(lo_reg);
  end

  // accumulator operand select
  always_comb begin
    if (state == S_YHI) begin
      sat_acc = x_accum;
      sat_sub = step_neg ^ trig.cos_neg;
    end else begin
      sat_acc = y_accum;
      sat_sub = step_neg ^ trig.sin_neg;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) begin
                 state_next = S_MAG;
               end
      S_MAG:   state_next = S_XLO;
      S_XLO:   state_next = S_XHI;
      S_XHI:   state_next = S_YLO;
      S_YLO:   state_next = S_YHI;
      S_YHI:   state_next = S_YCMB;
      S_YCMB:  state_next = S_YACC;
      S_YACC:  state_next = S_OUT;
      S_OUT:   if (out_free) begin
                 state_next = S_IDLE;
               end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      x_accum    <= '0;
      y_accum    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        last_count <= tick.encoder_count;
      end
      if (state == S_YHI) begin
        x_accum <= sat_sum;
      end
      if (state == S_YACC) begin
        y_accum <= sat_sum;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pose.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      step_neg <= diff[drp_pkg::COUNT_W-1];
      step_mag <= diff[drp_pkg::COUNT_W-1] ? (~diff + 1'b1) : diff;
      head_reg <= tick.heading_deg;
    end
    if (state == S_XLO) begin
      m_reg <= mul_p[drp_pkg::MAG_W-1:0];
    end
    if (state == S_XHI || state == S_YHI) begin
      lo_reg <= mul_p[drp_pkg::PLO_W-1:0];
    end
    if (state == S_YLO || state == S_YCMB) begin
      prod_reg <= drp_pkg::STEP_W'(full >> TRIG_FRAC_BITS);
    end
    if (state == S_OUT && out_free) begin
      pose.x_scaled    <= x_accum;
      pose.y_scaled    <= y_accum;
      pose.heading_out <= head_reg;
    end
  end

  assign pose.valid = out_valid;

  `ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == S_MAG)
  `ASSERT_NEXT(a_count_kept, clk, rst, accept, last_count == $past(tick.encoder_count))
  `ASSERT_NEXT(a_x_only_in_yhi, clk, rst, state != S_YHI, $stable(x_accum))
  `ASSERT_NEXT(a_y_only_in_yacc, clk, rst, state != S_YACC, $stable(y_accum))
  `ASSERT_NEXT(a_result_posted, clk, rst, state == S_OUT && out_free, out_valid)

endmodule
